### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

  localparam int CAPACITY       = 16;
  localparam int ELEMENT_WIDTH  = 16;
  localparam int PRIORITY_WIDTH = 16;
  localparam int CNT_W          = $clog2(CAPACITY + 1);

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_MODIFY  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Status codes of a response.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Action that all cells of the chain take together.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_REMOVE,
    CELL_CLEAR
  } cell_op_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REINSERT,
    ST_RESP
  } state_e;

  typedef logic [ELEMENT_WIDTH-1:0]  elem_t;
  typedef logic [PRIORITY_WIDTH-1:0] prio_t;

  // Request transaction.
  typedef struct packed {
    op_e         op;
    logic [15:0] element;
    logic [15:0] priority_req;
  } req_t;

  // Response transaction.
  typedef struct packed {
    status_e     status;
    logic [15:0] taken_element;
    logic [4:0]  entry_count;
    logic        top_valid;
    logic [15:0] top_element;
    logic [15:0] top_priority;
  } rsp_t;

  // Contents of one slot, as passed between neighboring cells.
  typedef struct packed {
    logic  valid;
    elem_t elem;
    prio_t prio;
  } slot_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    cell_op_e op;
    elem_t    elem;
    prio_t    prio;
  } cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      left_i,
  input  logic       left_ge_i,
  input  slot_t      right_i,
  input  logic       found_i,
  output slot_t      slot_o,
  output logic       ge_o,
  output logic       found_o
);

  logic  valid_q, valid_d;
  elem_t elem_q, elem_d;
  prio_t prio_q, prio_d;
  logic  match;

  // Local compares against the broadcast key.
  assign ge_o    = valid_q && ($signed(prio_q) >= $signed(ctrl_i.prio));
  assign match   = valid_q && (elem_q == ctrl_i.elem);
  assign found_o = found_i | match;

  // Next slot contents from this cell and its neighbors.
  always_comb begin
    valid_d = valid_q;
    elem_d  = elem_q;
    prio_d  = prio_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!ge_o) begin
          if (left_ge_i) begin
            valid_d = 1'b1;
            elem_d  = ctrl_i.elem;
            prio_d  = ctrl_i.prio;
          end else begin
            valid_d = left_i.valid;
            elem_d  = left_i.elem;
            prio_d  = left_i.prio;
          end
        end
      end
      CELL_SHIFT: begin
        valid_d = right_i.valid;
        elem_d  = right_i.elem;
        prio_d  = right_i.prio;
      end
      CELL_REMOVE: begin
        if (found_o) begin
          valid_d = right_i.valid;
          elem_d  = right_i.elem;
          prio_d  = right_i.prio;
        end
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    prio_q <= prio_d;
  end

  assign slot_o = '{valid: valid_q, elem: elem_q, prio: prio_q};

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer, count and cell chain.
// Depends on spq_pkg and spq_cell.
//
// Usage: a request transaction (op, element, priority_req) is accepted at a
// rising edge where start_i is high and busy_o is low. Each request yields
// exactly one response transaction on rsp_o, marked by rsp_valid_o for one
// cycle; the receiver cannot stall it.
// Insert, extract and clear update the whole chain of cells in the accept
// cycle: every cell compares its entry with the broadcast key and either
// holds, takes the new entry or takes a neighbor's entry. The response
// appears in the next cycle, and a new
// request may be accepted in the response cycle.
// Modify key runs two chain passes: the first removes the first matching
// entry, the second reinserts it; busy_o is high during the second pass.
// Equal priorities leave in arrival order.
// Reset empties the queue; the first request may be accepted right after.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;
  elem_t            taken_q, taken_d;
  elem_t            key_elem_q;
  prio_t            key_prio_q;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             full;
  logic             empty;
  elem_t            req_elem;
  prio_t            req_prio;

  slot_t             slots [CAPACITY];
  logic              ge    [CAPACITY];
  logic [CAPACITY:0] found;
  logic [CAPACITY-1:0] valid_vec;

  assign req_elem = ELEMENT_WIDTH'(req_i.element);
  assign req_prio = PRIORITY_WIDTH'(req_i.priority_req);
  assign busy_o   = (state_q == ST_REINSERT);
  assign accept   = start_i && !busy_o;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);

  // Chain of cells; the found flag ripples from the head to the tail.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_ge;
    if (i == 0) begin : g_head
      assign left_slot = '{valid: 1'b1, elem: '0, prio: '0};
      assign left_ge   = 1'b1;
    end else begin : g_mid
      assign left_slot = slots[i-1];
      assign left_ge   = ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '{valid: 1'b0, elem: '0, prio: '0};
    end else begin : g_body
      assign right_slot = slots[i+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_slot),
      .left_ge_i (left_ge),
      .right_i   (right_slot),
      .found_i   (found[i]),
      .slot_o    (slots[i]),
      .ge_o      (ge[i]),
      .found_o   (found[i+1])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  // Sequencer: chain action, count, status and next state.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    status_d  = status_q;
    taken_d   = taken_q;
    ctrl.op   = CELL_HOLD;
    ctrl.elem = req_elem;
    ctrl.prio = req_prio;
    case (state_q)
      ST_REINSERT: begin
        ctrl.op   = CELL_INSERT;
        ctrl.elem = key_elem_q;
        ctrl.prio = key_prio_q;
        count_d   = count_q + 1'b1;
        state_d   = ST_RESP;
      end
      ST_IDLE, ST_RESP: begin
        if (accept) begin
          status_d = STAT_OK;
          taken_d  = '0;
          state_d  = ST_RESP;
          case (req_i.op)
            OP_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            OP_EXTRACT: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.op = CELL_SHIFT;
                taken_d = slots[0].elem;
                count_d = count_q - 1'b1;
              end
            end
            OP_MODIFY: begin
              if (found[CAPACITY]) begin
                ctrl.op = CELL_REMOVE;
                count_d = count_q - 1'b1;
                state_d = ST_REINSERT;
              end else begin
                status_d = STAT_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              ctrl.op = CELL_CLEAR;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Response payload and the saved key for the reinsert pass.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    taken_q  <= taken_d;
    if (accept) begin
      key_elem_q <= req_elem;
      key_prio_q <= req_prio;
    end
  end

  // Response fields; the head is read straight from the first cell.
  assign rsp_valid_o         = (state_q == ST_RESP);
  assign rsp_o.status        = status_q;
  assign rsp_o.taken_element = 16'(taken_q);
  assign rsp_o.entry_count   = 5'(count_q);
  assign rsp_o.top_valid     = slots[0].valid;
  assign rsp_o.top_element   = slots[0].valid ? 16'(slots[0].elem) : '0;
  assign rsp_o.top_priority  = slots[0].valid ? 16'(slots[0].prio) : '0;

  // The count never exceeds the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count always equals the number of valid cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(valid_vec)))
    else $error("entry count disagrees with cell valid bits");

  // Valid cells form an unbroken run from the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("gap in the cell chain");

  // A reinsert pass is always followed by its response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REINSERT) |=> rsp_valid_o)
    else $error("modify finished without a response");

endmodule

### tb/sv/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: a directed table followed by
// random insert/extract/modify/clear traffic under several sender idle patterns.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  // One row of the directed table; pinned rows carry a hand-written response.
  typedef struct {
    req_t req;
    bit   pinned;
    rsp_t rsp;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic rsp_valid_o;
  rsp_t rsp_o;

  // Shadow copy of the queue contents, head at index 0.
  elem_t held_elem [CAPACITY];
  prio_t held_prio [CAPACITY];
  int    held_count = 0;

  rsp_t      pending_rsp [$];
  plan_row_t directed_plan [$];
  int        mismatch_count = 0;

  sorted_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous limit on the whole run.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Insert behind every entry of equal or higher priority.
  function automatic void place_entry(elem_t e, prio_t p);
    int pos;
    pos = 0;
    while (pos < held_count && $signed(held_prio[pos]) >= $signed(p)) pos++;
    for (int i = held_count; i > pos; i--) begin
      held_elem[i] = held_elem[i-1];
      held_prio[i] = held_prio[i-1];
    end
    held_elem[pos] = e;
    held_prio[pos] = p;
    held_count++;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_elem[i] = held_elem[i+1];
      held_prio[i] = held_prio[i+1];
    end
    held_count--;
  endfunction

  // Apply one request to the shadow queue and return the response it yields.
  function automatic rsp_t advance_queue_model(req_t r);
    rsp_t res;
    int   hit;
    res = '0;
    res.status = STAT_OK;
    case (r.op)
      OP_INSERT: begin
        if (held_count >= CAPACITY) res.status = STAT_FULL;
        else place_entry(r.element, r.priority_req);
      end
      OP_EXTRACT: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.taken_element = held_elem[0];
          drop_entry(0);
        end
      end
      OP_MODIFY: begin
        hit = -1;
        for (int i = 0; i < held_count; i++)
          if (hit < 0 && held_elem[i] == r.element) hit = i;
        if (hit < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          drop_entry(hit);
          place_entry(r.element, r.priority_req);
        end
      end
      default: held_count = 0;
    endcase
    res.entry_count = 5'(held_count);
    if (held_count > 0) begin
      res.top_valid    = 1'b1;
      res.top_element  = held_elem[0];
      res.top_priority = held_prio[0];
    end
    return res;
  endfunction

  function automatic plan_row_t mk_row(op_e op, elem_t e, prio_t p, bit pin = 1'b0,
                                       status_e st = STAT_OK, elem_t taken = '0,
                                       logic [4:0] cnt = '0, logic tv = 1'b0,
                                       elem_t te = '0, prio_t tp = '0);
    plan_row_t row;
    row.req.op               = op;
    row.req.element          = e;
    row.req.priority_req     = p;
    row.pinned               = pin;
    row.rsp.status           = st;
    row.rsp.taken_element    = taken;
    row.rsp.entry_count      = cnt;
    row.rsp.top_valid        = tv;
    row.rsp.top_element      = te;
    row.rsp.top_priority     = tp;
    return row;
  endfunction

  // Random request; insert_w sets how strongly the queue tends to fill.
  function automatic req_t random_request(int insert_w);
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 2) r.op = OP_CLEAR;
    else if (pick < 20) r.op = OP_MODIFY;
    else if (pick < 20 + insert_w) r.op = OP_INSERT;
    else r.op = OP_EXTRACT;

    // A small pool of elements makes duplicates common.
    pick = $urandom_range(99);
    if (pick < 40) r.element = elem_t'($urandom_range(7));
    else if (pick < 50) r.element = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else r.element = elem_t'($urandom);
    if (r.op == OP_MODIFY && held_count > 0 && $urandom_range(3) != 0)
      r.element = held_elem[$urandom_range(held_count - 1)];

    // Clustered priorities give frequent ties.
    pick = $urandom_range(99);
    if (pick < 40) r.priority_req = prio_t'($urandom_range(6) - 3);
    else if (pick < 55) r.priority_req = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else r.priority_req = prio_t'($urandom);
    return r;
  endfunction

  // Present a request, hold it until accepted, then record its response.
  task automatic issue_request(input req_t r, input bit pinned, input rsp_t pinned_rsp);
    rsp_t predicted;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = advance_queue_model(r);
    pending_rsp.push_back(pinned ? pinned_rsp : predicted);
  endtask

  task automatic sender_gap(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct && n < 40) n++;
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every outstanding response has arrived.
  task automatic drain_responses();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Compare each response transaction with the oldest outstanding prediction.
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rsp_valid_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, actual %h", $time, rsp_o);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, rsp_o.status);
        check_field("taken_element", want.taken_element, rsp_o.taken_element);
        check_field("entry_count", want.entry_count, rsp_o.entry_count);
        check_field("top_valid", want.top_valid, rsp_o.top_valid);
        check_field("top_element", want.top_element, rsp_o.top_element);
        check_field("top_priority", want.top_priority, rsp_o.top_priority);
      end
    end
  end

  initial begin : stimulus
    int phase_idle [4];
    int insert_w;
    bit quiet;
    phase_idle = '{0, 76, 0, 19};
    insert_w   = 45;
    quiet      = 1'b0;
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty-queue errors, extreme values, ties, full queue.
    directed_plan.push_back(mk_row(OP_EXTRACT, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY));
    directed_plan.push_back(mk_row(OP_MODIFY, 16'h1234, 16'h0000, 1'b1, STAT_NOT_FOUND));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hFFFF, 16'h7FFF, 1'b1, STAT_OK, 16'h0000,
                                   5'd1, 1'b1, 16'hFFFF, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h0000, 16'h8000, 1'b1, STAT_OK, 16'h0000,
                                   5'd2, 1'b1, 16'hFFFF, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hAAAA, 16'h0000));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h5555, 16'hFFFF));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h0001, 16'h0001));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h8000, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h1234, 16'h8000));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hAAAA, 16'h5555));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h7FFF, 16'hAAAA));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h00FF, 16'h0000));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hFF00, 16'hFFFE));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h0F0F, 16'h7FFE));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hF0F0, 16'h8001));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h3C3C, 16'h0002));
    directed_plan.push_back(mk_row(OP_INSERT, 16'hC3C3, 16'h0000));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h0002, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_INSERT, 16'h6666, 16'h7FFF, 1'b1, STAT_FULL, 16'h0000,
                                   5'd16, 1'b1, 16'hFFFF, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_MODIFY, 16'hAAAA, 16'h8000));
    directed_plan.push_back(mk_row(OP_MODIFY, 16'h0000, 16'h7FFF));
    directed_plan.push_back(mk_row(OP_EXTRACT, 16'h0000, 16'h0000));
    directed_plan.push_back(mk_row(OP_CLEAR, 16'h0000, 16'h0000, 1'b1, STAT_OK));
    directed_plan.push_back(mk_row(OP_EXTRACT, 16'hFFFF, 16'hFFFF, 1'b1, STAT_EMPTY));
    foreach (directed_plan[i])
      issue_request(directed_plan[i].req, directed_plan[i].pinned, directed_plan[i].rsp);
    drain_responses();

    // Random traffic in four phases, each with its own sender idle rate.
    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 360; k++) begin
        // Every 32 transactions, pick a fill tendency and maybe a burst without gaps.
        if (k % 32 == 0) begin
          case ($urandom_range(2))
            0: insert_w = 25;
            1: insert_w = 45;
            default: insert_w = 65;
          endcase
          quiet = ($urandom_range(3) == 0);
        end
        issue_request(random_request(insert_w), 1'b0, '0);
        sender_gap(quiet ? 0 : phase_idle[phase]);
      end
      drain_responses();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
